// File: rtl/vertex_spring_damper_jiggle_top_defines.svh
// Assertion macros used by the checker file of the jiggle block.
`ifndef VERTEX_SPRING_DAMPER_JIGGLE_TOP_DEFINES_SVH
`define VERTEX_SPRING_DAMPER_JIGGLE_TOP_DEFINES_SVH

// Overlapping implication, disabled while reset is low.
`define VSDJ_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VSDJ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/vsdj_pkg.sv
// Types and constants of the vertex spring-damper jiggle block.
package vsdj_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned AXES    = 3;
  localparam int unsigned WORD_W  = 2 * AXES * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_TREMBLE = 2'd0,
    REQ_CLASH   = 2'd1,
    REQ_STEP    = 2'd2,
    REQ_RESET   = 2'd3
  } req_type_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FRAC_BITS = 2'd0,
    CFG_SPRING    = 2'd1,
    CFG_DAMPING   = 2'd2,
    CFG_DURATION  = 2'd3
  } cfg_index_e;

  // What the write-back does with one vertex.
  typedef enum logic [2:0] {
    MODE_TREMBLE = 3'd0,
    MODE_CLASH   = 3'd1,
    MODE_REST    = 3'd2,
    MODE_HOLD    = 3'd3,
    MODE_UPDATE  = 3'd4
  } op_mode_e;

  // Sequencer states for one request in flight.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DAMP = 2'd2,
    ST_DONE = 2'd3
  } seq_state_e;

  // Stage enables for the per-axis integrator.
  typedef struct packed {
    logic mul_en;
    logic damp_en;
  } lane_ctrl_t;

  // Effect flags.
  typedef struct packed {
    logic active;
    logic frozen;
    logic expiring;
  } flags_t;

endpackage

// File: rtl/vsdj_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vsdj_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/vsdj_lane.sv
// One axis of the spring-damper integrator: spring multiply, damping multiply, position add.
module vsdj_lane (
  input  logic                clk_i,
  input  vsdj_pkg::lane_ctrl_t ctrl_i,
  input  logic [3:0]          frac_i,
  input  vsdj_pkg::coord_t    spring_i,
  input  vsdj_pkg::coord_t    damp_i,
  input  vsdj_pkg::coord_t    rest_i,
  input  vsdj_pkg::coord_t    pos_rd_i,
  input  vsdj_pkg::coord_t    vel_rd_i,
  output vsdj_pkg::coord_t    pos_o,
  output vsdj_pkg::coord_t    vel_o
);
  import vsdj_pkg::*;

  coord_t             pos_q;
  coord_t             vel_q;
  coord_t             diff;
  coord_t             vel1;
  logic signed [31:0] prod1_d;
  logic signed [31:0] prod1_q;
  logic signed [31:0] prod2_d;
  logic signed [31:0] prod2_q;
  logic signed [31:0] shift1;
  logic signed [31:0] shift2;

  // Spring term from the stored position.
  assign diff    = rest_i - pos_rd_i;
  assign prod1_d = diff * spring_i;

  // Velocity after the spring kick, then damped.
  assign shift1  = prod1_q >>> frac_i;
  assign vel1    = vel_q + shift1[COORD_W-1:0];
  assign prod2_d = vel1 * damp_i;

  // Final velocity and position.
  assign shift2  = prod2_q >>> frac_i;
  assign vel_o   = shift2[COORD_W-1:0];
  assign pos_o   = pos_q + vel_o;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      pos_q   <= pos_rd_i;
      vel_q   <= vel_rd_i;
      prod1_q <= prod1_d;
    end
    if (ctrl_i.damp_en) begin
      prod2_q <= prod2_d;
    end
  end

endmodule

// File: rtl/vertex_spring_damper_jiggle_top.sv
// An accepted request passes the states ST_MUL, ST_DAMP and ST_DONE to its result in the
// output register. One request is in flight at a time, set by the state RAM read, the
// two registered multiply steps and the write-back of the same entry.
// A waiting result does not block the next request; only the write-back stage waits for it.
// Reset clears the effect flags, the frame timer, the configuration and the handshakes;
// the vertex RAM is not cleared and holds nothing meaningful until written.
module vertex_spring_damper_jiggle_top #(
  parameter int unsigned VERTS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_wdata_i,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_index[9:0], rest_x[25:10], rest_y[41:26], rest_z[57:42],
  // kick_x[73:58], kick_y[89:74], kick_z[105:90], zero fill [111:106]
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // last_vertex
  input  logic [1:0]   s_axis_tuser,   // req_type
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32]
  output logic [47:0]  m_axis_tdata,
  output logic         m_axis_tuser    // effect_active
);
  import vsdj_pkg::*;

  localparam int unsigned AW = (VERTS > 1) ? $clog2(VERTS) : 1;

  // Configuration registers.
  logic [3:0]  frac_q;
  coord_t      spring_q;
  coord_t      damp_q;
  logic [15:0] duration_q;

  // Effect state.
  flags_t      flags_q, flags_d;
  logic [15:0] frames_q, frames_d;

  // Request in flight.
  seq_state_e  state_q, state_d;
  op_mode_e    mode_q, mode_d;
  logic        zero_gain_q, zero_gain_d;
  logic        eff_q, eff_d;
  logic [AW-1:0] addr_q, addr_d;
  coord_t      rest_q [AXES];
  coord_t      kick_q [AXES];

  // Output register.
  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic        m_user_q;

  logic        in_req;
  logic        out_free;
  logic        done_go;
  req_type_e   req;
  logic [9:0]  vi_mod;
  logic [AW+9:0] addr_wide;
  lane_ctrl_t  lane_ctrl;
  coord_t      spring_eff;
  coord_t      damp_eff;
  logic        ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  coord_t      lane_pos [AXES];
  coord_t      lane_vel [AXES];
  coord_t      wr_pos   [AXES];
  coord_t      wr_vel   [AXES];
  coord_t      shown    [AXES];

  // Vertex index reduced modulo the store depth by compare and subtract.
  function automatic logic [9:0] vert_mod(input logic [9:0] v);
    logic [31:0] r;
    r = {22'd0, v};
    for (int k = 9; k >= 0; k--) begin
      if (r >= (32'(VERTS) << k)) begin
        r = r - (32'(VERTS) << k);
      end
    end
    return r[9:0];
  endfunction

  assign vi_mod    = vert_mod(s_axis_tdata[9:0]);
  assign addr_wide = {{AW{1'b0}}, vi_mod};
  assign addr_d    = addr_wide[AW-1:0];
  assign req       = req_type_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign done_go       = (state_q == ST_DONE) && out_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q     <= '0;
      spring_q   <= '0;
      damp_q     <= '0;
      duration_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FRAC_BITS: frac_q     <= cfg_wdata_i[3:0];
        CFG_SPRING:    spring_q   <= cfg_wdata_i;
        CFG_DAMPING:   damp_q     <= cfg_wdata_i;
        CFG_DURATION:  duration_q <= cfg_wdata_i;
      endcase
    end
  end

  // Flag and timer update and write-back mode, decided when the request is taken.
  always_comb begin
    flags_d     = flags_q;
    frames_d    = frames_q;
    mode_d      = MODE_HOLD;
    zero_gain_d = flags_q.frozen;
    unique case (req)
      REQ_TREMBLE: begin
        flags_d  = '{active: 1'b1, frozen: 1'b0, expiring: 1'b0};
        frames_d = duration_q;
        mode_d   = MODE_TREMBLE;
      end
      REQ_CLASH: begin
        flags_d = '{active: 1'b1, frozen: 1'b1, expiring: 1'b0};
        mode_d  = MODE_CLASH;
      end
      REQ_STEP: begin
        if (flags_q.active) begin
          if (!flags_q.frozen && !flags_q.expiring && (addr_d == '0)) begin
            if (frames_q <= 16'd1) begin
              flags_d.expiring = 1'b1;
            end else begin
              frames_d = frames_q - 16'd1;
            end
          end
          mode_d = flags_d.expiring ? MODE_REST : MODE_UPDATE;
        end
      end
      REQ_RESET: begin
        mode_d = MODE_REST;
        if (flags_q.active) begin
          flags_d.expiring = 1'b1;
        end
      end
    endcase
    // The end of a pass closes an expiring effect.
    if (s_axis_tlast && flags_d.expiring) begin
      flags_d = '0;
    end
    eff_d = flags_d.active && !flags_d.expiring;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      frames_q <= '0;
    end else if (in_req) begin
      flags_q  <= flags_d;
      frames_q <= frames_d;
    end
  end

  // Request payload captured at accept.
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      mode_q      <= mode_d;
      zero_gain_q <= zero_gain_d;
      eff_q       <= eff_d;
      addr_q      <= addr_d;
      for (int a = 0; a < AXES; a++) begin
        rest_q[a] <= s_axis_tdata[10 + a*COORD_W +: COORD_W];
        kick_q[a] <= s_axis_tdata[58 + a*COORD_W +: COORD_W];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    lane_ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        lane_ctrl.mul_en = 1'b1;
        state_d          = ST_DAMP;
      end
      ST_DAMP: begin
        lane_ctrl.damp_en = 1'b1;
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Vertex state RAM: positions in the low half, velocities in the high half.
  vsdj_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VERTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_req),
    .raddr_i (addr_d),
    .rdata_o (ram_rdata)
  );

  // A frozen vertex sees both gains as zero.
  assign spring_eff = zero_gain_q ? coord_t'(0) : spring_q;
  assign damp_eff   = zero_gain_q ? coord_t'(0) : damp_q;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    vsdj_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .frac_i   (frac_q),
      .spring_i (spring_eff),
      .damp_i   (damp_eff),
      .rest_i   (rest_q[g]),
      .pos_rd_i (ram_rdata[g*COORD_W +: COORD_W]),
      .vel_rd_i (ram_rdata[(AXES + g)*COORD_W +: COORD_W]),
      .pos_o    (lane_pos[g]),
      .vel_o    (lane_vel[g])
    );
  end

  // Write-back values and shown position per mode.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      wr_pos[a] = rest_q[a];
      wr_vel[a] = '0;
      shown[a]  = rest_q[a];
      unique case (mode_q)
        MODE_TREMBLE: wr_vel[a] = kick_q[a];
        MODE_CLASH: begin
          wr_pos[a] = rest_q[a] + kick_q[a];
          wr_vel[a] = kick_q[a];
          shown[a]  = wr_pos[a];
        end
        MODE_UPDATE: begin
          wr_pos[a] = lane_pos[a];
          wr_vel[a] = lane_vel[a];
          shown[a]  = lane_pos[a];
        end
        MODE_REST, MODE_HOLD: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_we = done_go && (mode_q != MODE_HOLD);
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ram_wdata[a*COORD_W +: COORD_W]          = wr_pos[a];
      ram_wdata[(AXES + a)*COORD_W +: COORD_W] = wr_vel[a];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_go) begin
      m_data_q <= {shown[2], shown[1], shown[0]};
      m_user_q <= eff_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: rtl/vsdj_checker.sv
// Port-level checker for the jiggle block and its bind to the top level.
`include "vertex_spring_damper_jiggle_top_defines.svh"

module vsdj_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata,
  input logic         m_axis_tuser
);

  logic in_req;
  logic out_stall;

  assign in_req    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Only one request is in flight: the input closes right after a request.
  `VSDJ_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_req, !s_axis_tready, "input open after request")

  // A request is followed by a valid result in the output register (an older one while the output stalls).
  `VSDJ_ASSERT_IMPLY(a_result_due, clk_i, rst_ni, in_req, ##4 m_axis_tvalid, "result missing after request")

  // A stalled result holds its value.
  `VSDJ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind vertex_spring_damper_jiggle_top vsdj_checker u_checker (.*);

// File: tb/vsdj_jiggle_checker.sv
// Watches the jiggle block's channels, predicts each vertex result and compares it.
module vsdj_jiggle_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           err_count_o,
  output int           pending_o
);
  import vsdj_pkg::*;

  // One predicted vertex result.
  typedef struct {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   active;
  } vertex_out_t;

  // Predicted copy of the vertex store and the effect state.
  coord_t      pos_mem [1024][3];
  coord_t      vel_mem [1024][3];
  logic        active_q;
  logic        frozen_q;
  logic        expiring_q;
  logic [15:0] frames_q;

  // Predicted copy of the configuration.
  logic [3:0]  frac_q;
  coord_t      spring_q;
  coord_t      damp_q;
  logic [15:0] duration_q;

  vertex_out_t expected_pos_q[$];
  vertex_out_t got;
  vertex_out_t want;
  int          errors;

  // Applies one request to the predicted state and returns the displayed vertex.
  function automatic vertex_out_t advance_vertex(input logic [1:0] kind, input logic last,
                                                 input logic [111:0] word);
    vertex_out_t        res;
    logic [9:0]         vi;
    coord_t             rest [3];
    coord_t             kick [3];
    coord_t             shown [3];
    coord_t             p;
    coord_t             v;
    coord_t             dd;
    logic signed [31:0] wide;
    logic signed [31:0] gain_s;
    logic signed [31:0] gain_d;
    logic signed [31:0] prod;
    logic signed [31:0] shifted;
    vi = word[9:0];
    for (int a = 0; a < 3; a++) begin
      rest[a]  = word[10 + 16*a +: 16];
      kick[a]  = word[58 + 16*a +: 16];
      shown[a] = rest[a];
    end
    case (req_type_e'(kind))
      REQ_TREMBLE: begin
        for (int a = 0; a < 3; a++) begin
          pos_mem[vi][a] = rest[a];
          vel_mem[vi][a] = kick[a];
        end
        active_q   = 1'b1;
        frozen_q   = 1'b0;
        expiring_q = 1'b0;
        frames_q   = duration_q;
      end
      REQ_CLASH: begin
        for (int a = 0; a < 3; a++) begin
          pos_mem[vi][a] = rest[a] + kick[a];
          vel_mem[vi][a] = kick[a];
          shown[a]       = pos_mem[vi][a];
        end
        active_q   = 1'b1;
        frozen_q   = 1'b1;
        expiring_q = 1'b0;
      end
      REQ_STEP: begin
        if (active_q) begin
          // The frame timer counts passes at vertex zero.
          if (!frozen_q && !expiring_q && vi == 10'd0) begin
            if (frames_q <= 16'd1) expiring_q = 1'b1;
            else frames_q = frames_q - 16'd1;
          end
          if (expiring_q) begin
            for (int a = 0; a < 3; a++) begin
              pos_mem[vi][a] = rest[a];
              vel_mem[vi][a] = '0;
            end
          end else begin
            // A frozen vertex integrates with both gains at zero.
            gain_s = frozen_q ? 32'sd0 : spring_q;
            gain_d = frozen_q ? 32'sd0 : damp_q;
            for (int a = 0; a < 3; a++) begin
              p       = pos_mem[vi][a];
              v       = vel_mem[vi][a];
              dd      = rest[a] - p;
              wide    = dd;
              prod    = wide * gain_s;
              shifted = prod >>> frac_q;
              v       = v + shifted[15:0];
              wide    = v;
              prod    = gain_d * wide;
              shifted = prod >>> frac_q;
              v       = shifted[15:0];
              p       = p + v;
              vel_mem[vi][a] = v;
              pos_mem[vi][a] = p;
              shown[a]       = p;
            end
          end
        end
      end
      default: begin
        for (int a = 0; a < 3; a++) begin
          pos_mem[vi][a] = rest[a];
          vel_mem[vi][a] = '0;
        end
        if (active_q) expiring_q = 1'b1;
      end
    endcase
    // The effect ends after the last vertex of an expiring pass.
    if (last && expiring_q) begin
      active_q   = 1'b0;
      frozen_q   = 1'b0;
      expiring_q = 1'b0;
    end
    res.pos_x  = shown[0];
    res.pos_y  = shown[1];
    res.pos_z  = shown[2];
    res.active = active_q && !expiring_q;
    return res;
  endfunction

  // Compare results, predict accepted requests and track configuration writes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   = 1'b0;
      frozen_q   = 1'b0;
      expiring_q = 1'b0;
      frames_q   = '0;
      frac_q     = '0;
      spring_q   = '0;
      damp_q     = '0;
      duration_q = '0;
      expected_pos_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pos_q.size() == 0) begin
          $error("result with no request waiting: data %h active %b",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want       = expected_pos_q.pop_front();
          got.pos_x  = m_axis_tdata[15:0];
          got.pos_y  = m_axis_tdata[31:16];
          got.pos_z  = m_axis_tdata[47:32];
          got.active = m_axis_tuser;
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x mismatch: expected %0d, got %0d", want.pos_x, got.pos_x);
            errors++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y mismatch: expected %0d, got %0d", want.pos_y, got.pos_y);
            errors++;
          end
          if (got.pos_z !== want.pos_z) begin
            $error("pos_z mismatch: expected %0d, got %0d", want.pos_z, got.pos_z);
            errors++;
          end
          if (got.active !== want.active) begin
            $error("effect_active mismatch: expected %0b, got %0b", want.active, got.active);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pos_q.push_back(advance_vertex(s_axis_tuser, s_axis_tlast, s_axis_tdata));
      end
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_FRAC_BITS: frac_q     = cfg_wdata_i[3:0];
          CFG_SPRING:    spring_q   = cfg_wdata_i;
          CFG_DAMPING:   damp_q     = cfg_wdata_i;
          default:       duration_q = cfg_wdata_i;
        endcase
      end
    end
    err_count_o = errors;
    pending_o   = expected_pos_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the vertex spring-damper jiggle block.
module tb_top;
  import vsdj_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_index_i;
  logic [15:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  int           err_count;
  int           pending;
  logic         no_idle;
  int           rand_items;

  // Rest position per vertex and which store entries hold data.
  coord_t       rest_tab [1024][3];
  logic         written [1024];
  int           mesh_idx [8];
  int           mesh_n;

  always #1 clk_i = ~clk_i;

  vertex_spring_damper_jiggle_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  vsdj_jiggle_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // The result side stalls at random outside the calm stretch.
  always @(negedge clk_i) begin
    m_axis_tready = no_idle || ($urandom_range(99) >= 18);
  end

  // Either a full-range kick or a small one near zero.
  function automatic coord_t rand_kick();
    if ($urandom_range(1) == 1) return coord_t'($urandom_range(65535));
    return coord_t'($urandom_range(511) - 256);
  endfunction

  // Sends one request with the vertex's rest position; returns at the falling edge after it.
  task automatic send_req(input req_type_e req, input int vi, input logic last,
                          input coord_t kx, input coord_t ky, input coord_t kz);
    while (!no_idle && $urandom_range(99) < 18) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {6'b0, kz, ky, kx, rest_tab[vi][2], rest_tab[vi][1], rest_tab[vi][0],
                     10'(vi)};
    s_axis_tlast  = last;
    s_axis_tuser  = req;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (req != REQ_STEP) written[vi] = 1'b1;
    @(negedge clk_i);
  endtask

  // Lets every expected result arrive, then waits on with the input idle.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Writes all four registers, one per cycle.
  task automatic set_config(input logic [3:0] frac, input coord_t spring, input coord_t damp,
                            input logic [15:0] dur);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_FRAC_BITS;
    cfg_wdata_i = {12'b0, frac};
    @(negedge clk_i);
    cfg_index_i = CFG_SPRING;
    cfg_wdata_i = spring;
    @(negedge clk_i);
    cfg_index_i = CFG_DAMPING;
    cfg_wdata_i = damp;
    @(negedge clk_i);
    cfg_index_i = CFG_DURATION;
    cfg_wdata_i = dur;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Picks a gain, often at one of its extremes.
  function automatic coord_t rand_gain();
    int r;
    r = $urandom_range(99);
    if (r < 20) return coord_t'(16'h8000);
    if (r < 40) return coord_t'(16'h7fff);
    return coord_t'($urandom_range(65535));
  endfunction

  initial begin
    int   r;
    int   kind;
    int   vi;
    int   passes;
    logic [3:0]  frac;
    logic [15:0] dur;
    req_type_e   start_req;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_FRAC_BITS;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = REQ_STEP;
    no_idle       = 1'b0;
    rand_items    = 0;
    for (int i = 0; i < 1024; i++) begin
      written[i] = 1'b0;
      for (int a = 0; a < 3; a++) rest_tab[i][a] = '0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, timer expiry, freeze, reset request and wrapping.
    rest_tab[0]    = '{16'h7fff, 16'h8000, 16'h0000};
    rest_tab[1023] = '{16'h8000, 16'h7fff, 16'hffff};
    rest_tab[512]  = '{16'h1234, 16'hedcb, 16'h0001};
    set_config(4'd15, coord_t'(16'h8000), coord_t'(16'h7fff), 16'd2);
    send_req(REQ_TREMBLE, 0, 1'b0, 16'h8000, 16'h7fff, 16'hffff);
    send_req(REQ_TREMBLE, 1023, 1'b1, 16'h7fff, 16'h8000, 16'h0000);
    send_req(REQ_STEP, 0, 1'b0, '0, '0, '0);
    send_req(REQ_STEP, 1023, 1'b1, '0, '0, '0);
    send_req(REQ_STEP, 0, 1'b0, '0, '0, '0);
    send_req(REQ_STEP, 1023, 1'b1, '0, '0, '0);
    send_req(REQ_STEP, 0, 1'b1, '0, '0, '0);
    send_req(REQ_CLASH, 0, 1'b0, 16'h0001, 16'hffff, 16'h8000);
    send_req(REQ_STEP, 0, 1'b0, '0, '0, '0);
    send_req(REQ_STEP, 1023, 1'b1, '0, '0, '0);
    send_req(REQ_RESET, 1023, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
    send_req(REQ_STEP, 0, 1'b1, '0, '0, '0);
    send_req(REQ_RESET, 512, 1'b1, 16'h8000, 16'h8000, 16'h8000);
    wait_idle();
    // Zero duration expires on the very first step.
    set_config(4'd0, coord_t'(16'h7fff), coord_t'(16'h8000), 16'd0);
    send_req(REQ_TREMBLE, 0, 1'b0, rand_kick(), rand_kick(), rand_kick());
    send_req(REQ_STEP, 0, 1'b1, '0, '0, '0);
    wait_idle();
    // A long tremble with moderate gains.
    rest_tab[5] = '{16'h0100, 16'hff00, 16'h0040};
    set_config(4'd4, 16'sd12, 16'sd14, 16'hffff);
    send_req(REQ_TREMBLE, 0, 1'b0, 16'sd40, -16'sd40, 16'sd7);
    send_req(REQ_TREMBLE, 5, 1'b1, -16'sd90, 16'sd3, 16'sd100);
    repeat (3) begin
      send_req(REQ_STEP, 0, 1'b0, '0, '0, '0);
      send_req(REQ_STEP, 5, 1'b1, '0, '0, '0);
    end

    // Random phases: a fresh setting, a start over a small mesh, then passes of steps.
    while (rand_items < 1700) begin
      wait_idle();
      r    = $urandom_range(99);
      frac = (r < 15) ? 4'd0 : (r < 30) ? 4'd15 : 4'($urandom_range(10, 2));
      r    = $urandom_range(99);
      dur  = (r < 15) ? 16'd0 : (r < 25) ? 16'hffff : (r < 35) ? 16'd1 :
             16'($urandom_range(8, 2));
      set_config(frac, rand_gain(), rand_gain(), dur);

      mesh_n      = $urandom_range(8, 1);
      mesh_idx[0] = 0;
      for (int m = 1; m < mesh_n; m++) mesh_idx[m] = $urandom_range(1023, 1);
      for (int m = 0; m < mesh_n; m++) begin
        for (int a = 0; a < 3; a++) rest_tab[mesh_idx[m]][a] = coord_t'($urandom_range(65535));
      end

      start_req = ($urandom_range(99) < 75) ? REQ_TREMBLE : REQ_CLASH;
      for (int m = 0; m < mesh_n; m++) begin
        send_req(start_req, mesh_idx[m], m == mesh_n - 1, rand_kick(), rand_kick(), rand_kick());
        rand_items++;
      end

      passes = $urandom_range(8, 1);
      for (int p = 0; p < passes; p++) begin
        for (int m = 0; m < mesh_n; m++) begin
          no_idle = (rand_items >= 500 && rand_items < 800);
          r = $urandom_range(99);
          if (r < 4) begin
            send_req(REQ_RESET, mesh_idx[m], m == mesh_n - 1,
                     rand_kick(), rand_kick(), rand_kick());
          end else if (r < 9) begin
            // Noise: any kind at any vertex, never a step at an unwritten one.
            kind = $urandom_range(3);
            vi   = $urandom_range(1023);
            if (req_type_e'(kind) == REQ_STEP && !written[vi]) vi = mesh_idx[0];
            if ($urandom_range(1) == 1) begin
              for (int a = 0; a < 3; a++) rest_tab[vi][a] = coord_t'($urandom_range(65535));
            end
            send_req(req_type_e'(kind), vi, logic'($urandom_range(1)),
                     rand_kick(), rand_kick(), rand_kick());
          end else begin
            send_req(REQ_STEP, mesh_idx[m], m == mesh_n - 1, '0, '0, '0);
          end
          rand_items++;
        end
      end
    end

    no_idle = 1'b0;
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #800000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vsdj_pkg.sv
rtl/vsdj_ram.sv
rtl/vsdj_lane.sv
rtl/vertex_spring_damper_jiggle_top.sv
rtl/vsdj_checker.sv
tb/vsdj_jiggle_checker.sv
tb/tb_top.sv
